>>> hdl/lobm_pkg.sv
package lobm_pkg;

	localparam logic KIND_TRADE = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic fill;
		logic done;
	} lobm_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic scan_last;
		logic match_ok;
		logic remain_zero;
		logic fill_ends;
		logic out_free;
	} lobm_sts_t;

endpackage

>>> hdl/limit_order_book_matcher_top.sv
// Limit order book matcher, price-time priority.
// Input channel (in_valid/in_ready): one limit order per item. A buy trades
// against resting asks from the lowest price, a sell against resting bids
// from the highest, earliest order first within a price.
// Output channel (out_valid/out_ready): one trade item per fill, then one
// done item (last = 1) carrying the rested volume and the book-full flag.
// One order is worked at a time; in_ready is high only between orders.
// Each best-price search rotates the opposite side through one comparator,
// then a decide step picks a fill or the done item; a fill that leaves the
// order open starts a new search. in_ready returns the cycle after the done
// item is loaded, and the next order can be accepted in that cycle.
// The single output register sets the stall behavior: while out_ready is
// low a pending item holds and the fill or done step waits; the scan runs on.
// Reset clears both book sides to empty and sets the trade counter to 1;
// no clearing pass is needed.
module limit_order_book_matcher_top
	import lobm_pkg::*;
#(
	parameter int MAX_ORDERS  = 32,
	parameter int PRICE_BITS  = 20,
	parameter int VOLUME_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            order_number,
	input  logic                   is_buy,
	input  logic [PRICE_BITS-1:0]  limit_price,
	input  logic [VOLUME_BITS-1:0] order_volume,
	input  logic [47:0]            time_stamp,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   kind,
	output logic [31:0]            trade_number,
	output logic [31:0]            taker_number,
	output logic                   taker_buys,
	output logic [PRICE_BITS-1:0]  fill_price,
	output logic [VOLUME_BITS-1:0] fill_volume,
	output logic [47:0]            trade_time,
	output logic [VOLUME_BITS-1:0] rested_volume,
	output logic                   book_full,
	output logic                   last
);

	lobm_cmd_t cmd;
	lobm_sts_t sts;

	// sequencer: scan, decide, fill, done
	lobm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// book storage, comparator, trade counter and output register
	lobm_dp #(
		.MAX_ORDERS  (MAX_ORDERS),
		.PRICE_BITS  (PRICE_BITS),
		.VOLUME_BITS (VOLUME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.order_number  (order_number),
		.is_buy        (is_buy),
		.limit_price   (limit_price),
		.order_volume  (order_volume),
		.time_stamp    (time_stamp),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.trade_number  (trade_number),
		.taker_number  (taker_number),
		.taker_buys    (taker_buys),
		.fill_price    (fill_price),
		.fill_volume   (fill_volume),
		.trade_time    (trade_time),
		.rested_volume (rested_volume),
		.book_full     (book_full),
		.last          (last)
	);

`ifndef SYNTHESIS
	// an accepted order keeps the block busy through its search
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after an accepted order");

	// trade items never close an order
	a_trade_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_TRADE)) |-> !last)
		else $error("trade item marked last");

	// a dropped remainder rests nothing
	a_full_no_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && book_full) |-> (rested_volume == '0))
		else $error("book_full with nonzero rested_volume");
`endif

endmodule

>>> hdl/lobm_ctrl.sv
module lobm_ctrl
	import lobm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lobm_sts_t sts,
	output lobm_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_FILL,
		ST_DONE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load = in_valid && (state_q == ST_IDLE);
		cmd.scan = (state_q == ST_SCAN);
		cmd.fill = (state_q == ST_FILL) && sts.out_free;
		cmd.done = (state_q == ST_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (sts.remain_zero || !sts.match_ok) state_q <= ST_DONE;
					else state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (sts.out_free) begin
						if (sts.fill_ends) state_q <= ST_DONE;
						else state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/lobm_dp.sv
module lobm_dp
	import lobm_pkg::*;
#(
	parameter int MAX_ORDERS  = 32,
	parameter int PRICE_BITS  = 20,
	parameter int VOLUME_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lobm_cmd_t              cmd,
	output lobm_sts_t              sts,
	input  logic [31:0]            order_number,
	input  logic                   is_buy,
	input  logic [PRICE_BITS-1:0]  limit_price,
	input  logic [VOLUME_BITS-1:0] order_volume,
	input  logic [47:0]            time_stamp,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   kind,
	output logic [31:0]            trade_number,
	output logic [31:0]            taker_number,
	output logic                   taker_buys,
	output logic [PRICE_BITS-1:0]  fill_price,
	output logic [VOLUME_BITS-1:0] fill_volume,
	output logic [47:0]            trade_time,
	output logic [VOLUME_BITS-1:0] rested_volume,
	output logic                   book_full,
	output logic                   last
);

	localparam int IW = $clog2(MAX_ORDERS);
	localparam int CW = $clog2(MAX_ORDERS + 1);

	logic [PRICE_BITS-1:0]  price_q [2][MAX_ORDERS];
	logic [VOLUME_BITS-1:0] vol_q   [2][MAX_ORDERS];
	logic [CW-1:0]          count_q [2];

	logic [31:0]            taker_q;
	logic                   buy_q;
	logic [PRICE_BITS-1:0]  limit_q;
	logic [VOLUME_BITS-1:0] remain_q;
	logic [47:0]            time_q;
	logic [31:0]            trade_q;

	logic [IW-1:0]          cursor_q;
	logic                   found_q;
	logic [IW-1:0]          best_idx_q;
	logic [PRICE_BITS-1:0]  best_price_q;
	logic [VOLUME_BITS-1:0] best_vol_q;
	logic                   out_valid_q;

	logic                   opp;
	logic                   own;
	logic                   cur_valid;
	logic                   better;
	logic [VOLUME_BITS-1:0] fill_vol;
	logic                   removes;
	logic                   own_room;

	assign opp       = buy_q ? SIDE_ASK : SIDE_BID;
	assign own       = ~opp;
	assign cur_valid = CW'(cursor_q) < count_q[opp];
	assign better    = buy_q ? (price_q[opp][0] < best_price_q)
	                         : (price_q[opp][0] > best_price_q);
	assign fill_vol  = (remain_q < best_vol_q) ? remain_q : best_vol_q;
	assign removes   = (fill_vol == best_vol_q);
	assign own_room  = count_q[own] < CW'(MAX_ORDERS);

	always_comb begin
		sts.scan_last   = (cursor_q == IW'(MAX_ORDERS - 1));
		sts.match_ok    = found_q && (buy_q ? (limit_q >= best_price_q)
		                                    : (limit_q <= best_price_q));
		sts.remain_zero = (remain_q == '0);
		sts.fill_ends   = (fill_vol == remain_q);
		sts.out_free    = !out_valid_q || out_ready;
	end

	// taker registers and scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			taker_q  <= order_number;
			buy_q    <= is_buy;
			limit_q  <= limit_price;
			remain_q <= order_volume;
			time_q   <= time_stamp;
		end else if (cmd.fill) begin
			remain_q <= remain_q - fill_vol;
		end
		if (cmd.scan && cur_valid && (!found_q || better)) begin
			best_idx_q   <= cursor_q;
			best_price_q <= price_q[opp][0];
			best_vol_q   <= vol_q[opp][0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			found_q  <= 1'b0;
			trade_q  <= 32'd1;
		end else begin
			if (cmd.load || cmd.fill) begin
				cursor_q <= '0;
				found_q  <= 1'b0;
			end else if (cmd.scan) begin
				cursor_q <= sts.scan_last ? '0 : cursor_q + 1'b1;
				if (cur_valid) found_q <= 1'b1;
			end
			if (cmd.fill) trade_q <= trade_q + 32'd1;
		end
	end

	// book entries: rotate during scan, compact on removal, reduce on partial fill, append on rest
	always_ff @(posedge clk) begin
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < MAX_ORDERS; i++) begin
				if (cmd.scan && (s == int'(opp))) begin
					price_q[s][i] <= price_q[s][(i + 1) % MAX_ORDERS];
					vol_q[s][i]   <= vol_q[s][(i + 1) % MAX_ORDERS];
				end else if (cmd.fill && (s == int'(opp))) begin
					if (removes) begin
						if (IW'(i) >= best_idx_q) begin
							if (i < MAX_ORDERS - 1) begin
								price_q[s][i] <= price_q[s][i + 1];
								vol_q[s][i]   <= vol_q[s][i + 1];
							end else begin
								price_q[s][i] <= '0;
								vol_q[s][i]   <= '0;
							end
						end
					end else if (IW'(i) == best_idx_q) begin
						vol_q[s][i] <= vol_q[s][i] - fill_vol;
					end
				end else if (cmd.done && (s == int'(own)) && (remain_q != '0)
				             && (CW'(i) == count_q[s])) begin
					price_q[s][i] <= limit_q;
					vol_q[s][i]   <= remain_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q[0] <= '0;
			count_q[1] <= '0;
		end else begin
			if (cmd.fill && removes) begin
				count_q[opp] <= count_q[opp] - 1'b1;
			end
			if (cmd.done && (remain_q != '0) && own_room) begin
				count_q[own] <= count_q[own] + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fill || cmd.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			kind          <= KIND_TRADE;
			trade_number  <= trade_q;
			taker_number  <= taker_q;
			taker_buys    <= buy_q;
			fill_price    <= best_price_q;
			fill_volume   <= fill_vol;
			trade_time    <= time_q;
			rested_volume <= '0;
			book_full     <= 1'b0;
			last          <= 1'b0;
		end else if (cmd.done) begin
			kind          <= KIND_DONE;
			trade_number  <= '0;
			taker_number  <= taker_q;
			taker_buys    <= buy_q;
			fill_price    <= '0;
			fill_volume   <= '0;
			trade_time    <= time_q;
			rested_volume <= ((remain_q != '0) && own_room) ? remain_q : '0;
			book_full     <= (remain_q != '0) && !own_room;
			last          <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule
